FILE: design/decaying_detection_heat_map_assert.svh
// assertion macros for the heat map
`ifndef DECAYING_DETECTION_HEAT_MAP_ASSERT_SVH
`define DECAYING_DETECTION_HEAT_MAP_ASSERT_SVH

// same-cycle implication
`define DHM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heat map assertion failed");

// next-cycle implication
`define DHM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heat map assertion failed");

`endif

FILE: design/dhm_pkg.sv
`default_nettype none
package dhm_pkg;

    localparam logic [2:0] ACT_BEGIN  = 3'd0;
    localparam logic [2:0] ACT_DETECT = 3'd1;
    localparam logic [2:0] ACT_END    = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] CFG_GRID_W   = 3'd0;
    localparam logic [2:0] CFG_GRID_H   = 3'd1;
    localparam logic [2:0] CFG_DECAY    = 3'd2;
    localparam logic [2:0] CFG_CENTROID = 3'd3;
    localparam logic [2:0] CFG_AREA     = 3'd4;

    localparam logic [16:0] NORM_ONE   = 17'h10000;
    localparam int          PEAK_RESET = 256;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
        logic        is_motion;
        logic [11:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [16:0] heat_normalized;
        logic [23:0] heat_raw;
    } t_result;

    typedef enum logic [2:0] {
        OP_DECAY,
        OP_BOX,
        OP_PEAK,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] lin_start;
        logic [15:0] lin_end;
        logic        in_range;
        logic        area_on;
        logic [7:0]  x1;
        logic [7:0]  x2;
        logic [7:0]  y1;
        logic [7:0]  y2;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [8:0]  w;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FIN,
        ST_DIV
    } t_state;

    function automatic logic [7:0] clamp_pos(logic [8:0] pos, logic [8:0] n);
        return (pos >= n) ? 8'(n - 9'd1) : 8'(pos);
    endfunction

endpackage
`default_nettype wire

FILE: design/dhm_ram.sv
`default_nettype none
module dhm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: design/dhm_front.sv
`default_nettype none
module dhm_front #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64
) (
    input  wire logic          i_accept,
    input  wire dhm_pkg::t_item i_item,
    input  wire logic [6:0]    i_grid_width,
    input  wire logic [6:0]    i_grid_height,
    output logic               o_push,
    output dhm_pkg::t_cmd      o_cmd
);
    import dhm_pkg::*;

    logic [8:0]  wc, hc, gw9, gh9;
    logic [16:0] sum_x, sum_y;
    logic [25:0] p_cx, p_cy;
    logic [24:0] p_x1, p_x2, p_y1, p_y2;
    logic [17:0] used;
    logic [7:0]  x1, x2, y1, y2, cx, cy;
    logic        inverted, valid;

    always_comb begin
        gw9 = {2'b00, i_grid_width};
        gh9 = {2'b00, i_grid_height};
        wc = (gw9 == 9'd0) ? 9'd1 : ((gw9 > 9'(MAX_GRID_W)) ? 9'(MAX_GRID_W) : gw9);
        hc = (gh9 == 9'd0) ? 9'd1 : ((gh9 > 9'(MAX_GRID_H)) ? 9'(MAX_GRID_H) : gh9);
        sum_x = {1'b0, i_item.box_left} + {1'b0, i_item.box_right};
        sum_y = {1'b0, i_item.box_top} + {1'b0, i_item.box_bottom};
        p_cx = 26'(sum_x) * 26'(wc);
        p_cy = 26'(sum_y) * 26'(hc);
        p_x1 = 25'(i_item.box_left) * 25'(wc);
        p_x2 = 25'(i_item.box_right) * 25'(wc);
        p_y1 = 25'(i_item.box_top) * 25'(hc);
        p_y2 = 25'(i_item.box_bottom) * 25'(hc);
        used = 18'(wc) * 18'(hc);
        cx = clamp_pos(p_cx[25:17], wc);
        cy = clamp_pos(p_cy[25:17], hc);
        x1 = clamp_pos(p_x1[24:16], wc);
        x2 = clamp_pos(p_x2[24:16], wc);
        y1 = clamp_pos(p_y1[24:16], hc);
        y2 = clamp_pos(p_y2[24:16], hc);
        inverted = (x1 > x2) || (y1 > y2);
    end

    always_comb begin
        valid = 1'b1;
        o_cmd = '0;
        o_cmd.op = OP_DECAY;
        o_cmd.w = wc;
        o_cmd.cx = cx;
        o_cmd.cy = cy;
        o_cmd.area_on = !inverted;
        o_cmd.x1 = inverted ? cx : x1;
        o_cmd.x2 = inverted ? cx : x2;
        o_cmd.y1 = inverted ? cy : y1;
        o_cmd.y2 = inverted ? cy : y2;
        o_cmd.lin_start = 16'd0;
        o_cmd.lin_end = 16'(used - 18'd1);
        o_cmd.in_range = {6'd0, i_item.cell_index} < used;
        unique case (i_item.action)
            ACT_BEGIN: o_cmd.op = OP_DECAY;
            ACT_DETECT: begin
                o_cmd.op = OP_BOX;
                valid = !i_item.is_motion;
            end
            ACT_END: o_cmd.op = OP_PEAK;
            ACT_READ: begin
                o_cmd.op = OP_READ;
                o_cmd.lin_start = {4'd0, i_item.cell_index};
                o_cmd.lin_end = {4'd0, i_item.cell_index};
            end
            ACT_CLEAR: o_cmd.op = OP_CLEAR;
            default: valid = 1'b0;
        endcase
        o_push = i_accept && valid;
    end
endmodule
`default_nettype wire

FILE: design/dhm_queue.sv
`default_nettype none
module dhm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dhm_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output dhm_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);
    import dhm_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

FILE: design/dhm_back.sv
`default_nettype none
module dhm_back #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64,
    parameter int HEAT_BITS  = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire dhm_pkg::t_cmd i_cmd,
    input  wire logic [16:0]   i_decay_factor,
    input  wire logic [15:0]   i_centroid_weight,
    input  wire logic [15:0]   i_area_weight,
    output logic               o_pop,
    output logic               o_init,
    output logic               o_strobe,
    output dhm_pkg::t_result   o_result
);
    import dhm_pkg::*;

    localparam int CELLS = MAX_GRID_W * MAX_GRID_H;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int HB    = HEAT_BITS;
    localparam int SW    = ((HB > 17) ? HB : 17) + 1;
    localparam logic [HB-1:0] HEAT_MAX  = '1;
    localparam logic [HB-1:0] PEAK_INIT = HB'(PEAK_RESET);

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [AW-1:0] r_addr, r_end, r_rowbase, r_paddr;
    logic [7:0]    r_col, r_row;
    logic          r_pv, r_pcent, r_init, r_strobe;
    logic [HB-1:0] r_max, r_peak, r_raw, r_rem;
    logic [15:0]   r_quo;
    logic [3:0]    r_step;
    t_result       r_res;

    logic          lin, walk_last, clear_last, cur_cent;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [HB-1:0] wr_data, rd_data, dec, sat;
    logic [16:0]   dclamp, amt;
    logic [HB+16:0] prod;
    logic [SW-1:0] sum;
    logic [HB:0]   dtry;
    logic          ge;
    logic [HB-1:0] rem_n;
    logic [16:0]   rowbase0;

    dhm_ram #(.WIDTH(HB), .DEPTH(CELLS)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        lin        = (r_cmd.op != OP_BOX);
        walk_last  = lin ? (r_addr == r_end) : ((r_col == r_cmd.x2) && (r_row == r_cmd.y2));
        clear_last = (r_addr == AW'(CELLS - 1));
        cur_cent   = (r_col == r_cmd.cx) && (r_row == r_cmd.cy);
        dclamp     = (i_decay_factor > NORM_ONE) ? NORM_ONE : i_decay_factor;
        prod       = (HB + 17)'(rd_data) * (HB + 17)'(dclamp);
        dec        = prod[HB+15:16];
        amt        = (r_cmd.area_on ? {1'b0, i_area_weight} : 17'd0)
                   + (r_pcent ? {1'b0, i_centroid_weight} : 17'd0);
        sum        = SW'(rd_data) + SW'(amt);
        sat        = (sum > SW'(HEAT_MAX)) ? HEAT_MAX : HB'(sum);
        dtry       = {r_rem, 1'b0};
        ge         = dtry >= {1'b0, r_peak};
        rem_n      = ge ? HB'(dtry - {1'b0, r_peak}) : HB'(dtry);
        rowbase0   = 17'(i_cmd.y1) * 17'(i_cmd.w);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: n_state = clear_last ? ST_IDLE : ST_CLEAR;
            ST_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.op == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_cmd.op == OP_READ && !i_cmd.in_range) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK:  n_state = walk_last ? ST_DRAIN : ST_WALK;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN: begin
                n_state = (r_cmd.op == OP_READ && r_raw < r_peak) ? ST_DIV : ST_IDLE;
            end
            ST_DIV: n_state = (r_step == 4'd15) ? ST_IDLE : ST_DIV;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = lin ? r_addr : AW'(r_rowbase + AW'(r_col));
        wr_en   = 1'b0;
        wr_addr = r_paddr;
        wr_data = (r_cmd.op == OP_DECAY) ? dec : sat;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = '0;
            end
            ST_IDLE: o_pop = !i_empty;
            ST_WALK: rd_en = 1'b1;
            default: ;
        endcase
        if (r_pv && (r_cmd.op == OP_DECAY || r_cmd.op == OP_BOX)) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= rd_addr;
        r_pcent <= cur_cent;
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_init   <= 1'b1;
            r_peak   <= PEAK_INIT;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
            r_cmd    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            r_pv     <= (r_state == ST_WALK);
            if (r_pv) begin
                if (r_cmd.op == OP_PEAK && rd_data > r_max) begin
                    r_max <= rd_data;
                end
                if (r_cmd.op == OP_READ) begin
                    r_raw <= rd_data;
                end
            end
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (clear_last) begin
                        r_init <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_cmd     <= i_cmd;
                        r_addr    <= AW'(i_cmd.lin_start);
                        r_end     <= AW'(i_cmd.lin_end);
                        r_col     <= i_cmd.x1;
                        r_row     <= i_cmd.y1;
                        r_rowbase <= AW'(rowbase0);
                        r_max     <= PEAK_INIT;
                        if (i_cmd.op == OP_CLEAR) begin
                            r_addr <= '0;
                            r_peak <= PEAK_INIT;
                        end
                        if (i_cmd.op == OP_READ && !i_cmd.in_range) begin
                            r_strobe <= 1'b1;
                            r_res    <= '0;
                        end
                    end
                end
                ST_WALK: begin
                    if (lin) begin
                        r_addr <= r_addr + AW'(1);
                    end else if (r_col == r_cmd.x2) begin
                        r_col     <= r_cmd.x1;
                        r_row     <= r_row + 8'd1;
                        r_rowbase <= AW'(r_rowbase + AW'(r_cmd.w));
                    end else begin
                        r_col <= r_col + 8'd1;
                    end
                end
                ST_FIN: begin
                    if (r_cmd.op == OP_PEAK) begin
                        r_peak <= r_max;
                    end
                    if (r_cmd.op == OP_READ) begin
                        if (r_raw >= r_peak) begin
                            r_strobe                <= 1'b1;
                            r_res.heat_normalized   <= NORM_ONE;
                            r_res.heat_raw          <= 24'(r_raw);
                        end else begin
                            r_rem  <= r_raw;
                            r_quo  <= '0;
                            r_step <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem  <= rem_n;
                    r_quo  <= {r_quo[14:0], ge};
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_strobe              <= 1'b1;
                        r_res.heat_normalized <= {1'b0, r_quo[14:0], ge};
                        r_res.heat_raw        <= 24'(r_raw);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_init   = r_init;
    assign o_strobe = r_strobe;
    assign o_result = r_res;
endmodule
`default_nettype wire

FILE: design/decaying_detection_heat_map.sv
`default_nettype none
// Decaying detection heat map.
// Input channel: an item on i_item is taken at a clock edge where start is high
// and busy is low. Begin frame decays every cell in use, detection adds heat
// over the box, end frame latches the peak, read returns one cell, clear zeroes
// the grid. Motion detections and unknown actions are taken and dropped.
// Result channel: a read gives one beat on o_result, flagged by o_result_strobe
// for one cycle; the receiver cannot stall it.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data,
// always ready; write only while the block is idle.
// Items pass a two-entry command queue to a sequencer that walks one cell per
// cycle over the single-port-read heat RAM. A read of a cell below the peak
// runs a restoring division of the cell by the peak for its normalized value;
// a cell at or above the peak normalizes to NORM_ONE. An out-of-range read
// gives an all-zero beat straight from idle; a clear zeroes every cell of RAM.
// After reset the RAM is swept to zero over all MAX_GRID_W*MAX_GRID_H cells
// (4096 by default) with busy high; config writes are taken during the sweep.
module decaying_detection_heat_map #(
    parameter int MAX_GRID_W = 64,
    parameter int MAX_GRID_H = 64,
    parameter int HEAT_BITS  = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dhm_pkg::t_item   i_item,
    output logic                  o_result_strobe,
    output dhm_pkg::t_result      o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [16:0]      i_cfg_data
);
    import dhm_pkg::*;

`include "decaying_detection_heat_map_assert.svh"

    logic [6:0]  r_grid_width, r_grid_height;
    logic [16:0] r_decay_factor;
    logic [15:0] r_centroid_weight, r_area_weight;
    logic        accept, front_push, q_full, q_empty, q_pop, back_init;
    t_cmd        front_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full || back_init;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width      <= 7'd32;
            r_grid_height     <= 7'd32;
            r_decay_factor    <= 17'd62259;
            r_centroid_weight <= 16'd256;
            r_area_weight     <= 16'd51;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_W:   r_grid_width      <= i_cfg_data[6:0];
                CFG_GRID_H:   r_grid_height     <= i_cfg_data[6:0];
                CFG_DECAY:    r_decay_factor    <= i_cfg_data;
                CFG_CENTROID: r_centroid_weight <= i_cfg_data[15:0];
                CFG_AREA:     r_area_weight     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dhm_front #(.MAX_GRID_W(MAX_GRID_W), .MAX_GRID_H(MAX_GRID_H)) u_front (
        .i_accept      (accept),
        .i_item        (i_item),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    dhm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    dhm_back #(
        .MAX_GRID_W (MAX_GRID_W),
        .MAX_GRID_H (MAX_GRID_H),
        .HEAT_BITS  (HEAT_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_cmd             (q_cmd),
        .i_decay_factor    (r_decay_factor),
        .i_centroid_weight (r_centroid_weight),
        .i_area_weight     (r_area_weight),
        .o_pop             (q_pop),
        .o_init            (back_init),
        .o_strobe          (o_result_strobe),
        .o_result          (o_result)
    );

    `DHM_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, front_push, !q_full)
    `DHM_ASSERT_IMP(a_no_result_init, i_clk, i_rst_n, back_init, !o_result_strobe)
    `DHM_ASSERT_IMP(a_norm_bound, i_clk, i_rst_n, o_result_strobe, o_result.heat_normalized <= NORM_ONE)
endmodule
`default_nettype wire
